// ===== rtl/gip_pkg.sv =====
package gip_pkg;

  localparam int PIX_W   = 16;
  localparam int VAL_W   = 20;
  localparam int SUM_W   = 48;
  localparam int GAP_W   = 12;
  localparam int DUR_W   = 8;
  localparam int MM_W    = 16;
  localparam int NUM_PIX = 1 << PIX_W;

  // read-out: q = floor((3*|S| + bias) / 3200) done as ((3*|S| + bias) >> 7) / 25,
  // the /25 by reciprocal multiply; |S| >= 2^26 always saturates
  localparam int LOW_W   = 7;
  localparam int X_W     = 21;
  localparam int SAT_SH  = 26;
  localparam int RCP_W   = 22;
  localparam int RCP_SH  = 26;
  localparam int Q_W     = MM_W + 1;
  localparam int HALF_W  = 11;
  localparam int MUL_W   = GAP_W + VAL_W + 1;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [VAL_W-1:0] val_t;
  typedef logic [SUM_W-1:0] sum_t;
  typedef logic [GAP_W-1:0] gap_t;
  typedef logic [DUR_W-1:0] dur_t;
  typedef logic [MUL_W-1:0] mul_t;
  typedef logic [X_W+RCP_W-1:0] qprod_t;
  typedef logic [1:0]       op_t;

  localparam op_t OP_SAMPLE    = 2'd0;
  localparam op_t OP_MISS_LAST = 2'd1;
  localparam op_t OP_MISS_STEP = 2'd2;
  localparam op_t OP_READ      = 2'd3;

  localparam logic [RCP_W-1:0]     RECIP       = 22'd2684355;  // ceil(2^26 / 25)
  localparam logic [HALF_W-1:0]    HALF_UNIT   = 11'd1600;
  localparam sum_t                 MISSING_SUM = 48'hFFFF_FFFF_FFE0;  // -1.0 at 5 frac bits
  localparam dur_t                 DUR_STEP    = 8'd3;
  localparam logic [MM_W-1:0]      MM_MAX      = 16'h7FFF;
  localparam logic [MM_W-1:0]      MM_MIN      = 16'h8000;
  localparam int                   QDEPTH      = 2;

  typedef struct packed {
    op_t  op;
    pix_t pix;
    val_t val;
  } item_t;

  typedef struct packed {
    sum_t sum;
    gap_t gap;
    val_t last;
    logic have;
    dur_t dur;
  } entry_t;

endpackage

// ===== rtl/gip_if.sv =====
interface gip_in_if;
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic [gip_pkg::PIX_W-1:0]    pixel_index;
  logic signed [gip_pkg::VAL_W-1:0] rain_value;
  logic                         is_last_step;

  modport source(output valid, cmd, pixel_index, rain_value, is_last_step, input ready);
  modport sink(input valid, cmd, pixel_index, rain_value, is_last_step, output ready);
endinterface

interface gip_out_if;
  logic                         valid;
  logic                         ready;
  logic [gip_pkg::PIX_W-1:0]    out_pixel;
  logic signed [gip_pkg::MM_W-1:0] total_mm;
  logic [gip_pkg::DUR_W-1:0]    duration_hours;

  modport source(output valid, out_pixel, total_mm, duration_hours, input ready);
  modport sink(input valid, out_pixel, total_mm, duration_hours, output ready);
endinterface

// ===== rtl/gap_interpolating_pixel_accumulator.sv =====
// Per-pixel rain compositor. Sample words (cmd 0) add a three-hourly rate to a
// pixel, counting missing steps as a gap that the next valid rate fills by
// repetition or linear interpolation; read-out words (cmd 1) return rounded mm
// and duration and clear the pixel. After reset the block sweeps its 65536-entry
// pixel memory to zero, one entry per cycle, and takes no word until the sweep
// ends. A front stage classifies words into a 2-deep queue; the back end runs
// one word at a time through a read-modify-write of the pixel memory: a sample
// passes read, execute, one loop step per gap step if interpolating, write-back;
// a read-out passes read, execute, divide (the divide by 25 to mm is a single
// reciprocal multiply), result register and write-back, plus any wait there.
module gap_interpolating_pixel_accumulator (
  input  logic      clk,
  input  logic      rst_n,
  gip_in_if.sink    in_ch,
  gip_out_if.source out_ch
);

  logic           clearing;
  logic           push_valid, push_ready;
  gip_pkg::item_t push_item;
  logic           pop_valid, pop_ready;
  gip_pkg::item_t pop_item;

  // word intake and op decode
  gip_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .clearing   (clearing),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  // decouples intake from the memory engine
  gip_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item),
    .pop_ready  (pop_ready)
  );

  // pixel memory, gap fill, mm conversion, result register
  gip_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_item  (pop_item),
    .pop_ready (pop_ready),
    .out_ch    (out_ch),
    .clearing  (clearing)
  );

  // no result may appear while the memory sweep runs
  a_no_out_clr: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !out_ch.valid) else $error("result during clear sweep");

  // intake is closed during the sweep
  a_no_in_clr: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |-> !clearing) else $error("word taken during clear");

  // back end works on one word at a time
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    (pop_valid && pop_ready) |=> !pop_ready) else $error("back end overlapped words");

endmodule

// ===== rtl/gip_front.sv =====
module gip_front (
  input  logic            clk,
  input  logic            rst_n,
  gip_in_if.sink          in_ch,
  input  logic            clearing,
  output logic            push_valid,
  output gip_pkg::item_t  push_item,
  input  logic            push_ready
);

  logic           slot_v_r;
  gip_pkg::item_t slot_r;
  gip_pkg::item_t cls;
  logic           in_acc;

  assign in_ch.ready = !clearing && (!slot_v_r || push_ready);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign push_valid  = slot_v_r;
  assign push_item   = slot_r;

  // classify the word
  always_comb begin
    cls.pix = in_ch.pixel_index;
    cls.val = in_ch.rain_value;
    priority if (in_ch.cmd) begin
      cls.op = gip_pkg::OP_READ;
    end else if (!in_ch.rain_value[gip_pkg::VAL_W-1]) begin
      cls.op = gip_pkg::OP_SAMPLE;
    end else if (in_ch.is_last_step) begin
      cls.op = gip_pkg::OP_MISS_LAST;
    end else begin
      cls.op = gip_pkg::OP_MISS_STEP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_v_r <= 1'b0;
    end else if (in_acc) begin
      slot_v_r <= 1'b1;
    end else if (push_ready) begin
      slot_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      slot_r <= cls;
    end
  end

endmodule

// ===== rtl/gip_queue.sv =====
module gip_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  input  gip_pkg::item_t  push_item,
  output logic            push_ready,
  output logic            pop_valid,
  output gip_pkg::item_t  pop_item,
  input  logic            pop_ready
);

  gip_pkg::item_t ent_r [gip_pkg::QDEPTH];
  logic           wp_r, rp_r;
  logic [1:0]     cnt_r;
  logic           do_push, do_pop;

  assign push_ready = (cnt_r != 2'(gip_pkg::QDEPTH));
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_item   = ent_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= !wp_r;
      if (do_pop)  rp_r <= !rp_r;
      unique case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wp_r] <= push_item;
    end
  end

endmodule

// ===== rtl/gip_back.sv =====
module gip_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            pop_valid,
  input  gip_pkg::item_t  pop_item,
  output logic            pop_ready,
  gip_out_if.source       out_ch,
  output logic            clearing
);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_RD   = 4'd2;
  localparam logic [3:0] S_EXE  = 4'd3;
  localparam logic [3:0] S_LOOP = 4'd4;
  localparam logic [3:0] S_DIV  = 4'd5;
  localparam logic [3:0] S_RES  = 4'd7;
  localparam logic [3:0] S_WB   = 4'd8;

  gip_pkg::entry_t mem [gip_pkg::NUM_PIX];
  gip_pkg::entry_t rd_q;

  logic [3:0]                 st_r;
  gip_pkg::pix_t              clr_r;
  gip_pkg::item_t             item_r;
  gip_pkg::entry_t            ent_r;
  gip_pkg::sum_t              prod_r;
  logic                       neg_r;
  logic                       big_r;
  logic [gip_pkg::X_W-1:0]    dq_r;
  gip_pkg::gap_t              i_r;
  logic [gip_pkg::Q_W-1:0]    q_r;

  logic                       out_v_r;
  gip_pkg::pix_t              out_pix_r;
  logic [gip_pkg::MM_W-1:0]   out_mm_r;
  gip_pkg::dur_t              out_dur_r;

  logic                       we;
  gip_pkg::pix_t              wa;
  gip_pkg::entry_t            wd;

  // RD stage operands
  logic [gip_pkg::VAL_W:0]    mb;
  gip_pkg::mul_t              prod;
  gip_pkg::sum_t              mag;

  // EXE stage
  gip_pkg::sum_t              twov;
  logic [gip_pkg::GAP_W:0]    g3;
  logic                       v_pos, l_pos;
  logic [gip_pkg::SUM_W+1:0]  t3;
  logic [gip_pkg::HALF_W-1:0] bias;
  logic [gip_pkg::SUM_W+1:0]  t3b;

  // gap fill loop
  logic [gip_pkg::GAP_W+1:0]  a3, b3, gp1, g2;
  gip_pkg::gap_t              jj;
  logic [1:0]                 fa, fb;

  // mm conversion
  gip_pkg::qprod_t            qprod;
  logic [gip_pkg::MM_W-1:0]   mm;
  logic                       res_go;

  assign clearing  = (st_r == S_CLR);
  assign pop_ready = (st_r == S_IDLE);
  assign res_go    = (st_r == S_RES) && (!out_v_r || out_ch.ready);

  assign out_ch.valid          = out_v_r;
  assign out_ch.out_pixel      = out_pix_r;
  assign out_ch.total_mm       = out_mm_r;
  assign out_ch.duration_hours = out_dur_r;

  always_comb begin
    we = 1'b0;
    wa = item_r.pix;
    wd = ent_r;
    if (st_r == S_CLR) begin
      we = 1'b1;
      wa = clr_r;
      wd = '0;
    end else if (st_r == S_WB) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[pop_item.pix];
  end

  always_comb begin
    if (item_r.op == gip_pkg::OP_MISS_LAST) begin
      mb = {rd_q.last, 1'b0};
    end else if (rd_q.have) begin
      mb = {1'b0, rd_q.last} + {1'b0, item_r.val};
    end else begin
      mb = {item_r.val, 1'b0};
    end
    prod = gip_pkg::mul_t'(rd_q.gap) * gip_pkg::mul_t'(mb);
    mag  = rd_q.sum[gip_pkg::SUM_W-1] ? (~rd_q.sum + gip_pkg::sum_t'(1)) : rd_q.sum;
  end

  // rounding half up applies to non-negative sums only
  always_comb begin
    twov  = gip_pkg::sum_t'({item_r.val, 1'b0});
    g3    = {ent_r.gap, 1'b0} + {1'b0, ent_r.gap};
    v_pos = (item_r.val != '0);
    l_pos = (ent_r.last != '0);
    t3    = {prod_r, 1'b0} + {2'b00, prod_r};
    bias  = neg_r ? '0 : gip_pkg::HALF_UNIT;
    t3b   = t3 + {{(gip_pkg::SUM_W+2-gip_pkg::HALF_W){1'b0}}, bias};
  end

  // floor(3*i/(g+1)) only takes values 0..2: two compares
  always_comb begin
    jj  = ent_r.gap - i_r + gip_pkg::gap_t'(1);
    a3  = {1'b0, i_r, 1'b0} + {2'b00, i_r};
    b3  = {1'b0, jj, 1'b0} + {2'b00, jj};
    gp1 = {2'b00, ent_r.gap} + 14'd1;
    g2  = {gp1[gip_pkg::GAP_W:0], 1'b0};
    fa  = {1'b0, a3 >= gp1} + {1'b0, a3 >= g2};
    fb  = {1'b0, b3 >= gp1} + {1'b0, b3 >= g2};
  end

  // x / 25 as x * ceil(2^26/25) >> 26, exact for x < 2^21
  always_comb begin
    qprod = gip_pkg::qprod_t'(dq_r) * gip_pkg::qprod_t'(gip_pkg::RECIP);
  end

  always_comb begin
    if (big_r) begin
      mm = neg_r ? gip_pkg::MM_MIN : gip_pkg::MM_MAX;
    end else if (!neg_r) begin
      mm = (q_r > {1'b0, gip_pkg::MM_MAX}) ? gip_pkg::MM_MAX : q_r[gip_pkg::MM_W-1:0];
    end else begin
      mm = (q_r > {1'b0, gip_pkg::MM_MIN}) ? gip_pkg::MM_MIN
                                           : (~q_r[gip_pkg::MM_W-1:0] + 16'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_CLR;
      clr_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (res_go) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
      unique case (st_r)
        S_CLR: begin
          clr_r <= clr_r + gip_pkg::pix_t'(1);
          if (clr_r == '1) st_r <= S_IDLE;
        end
        S_IDLE: if (pop_valid) st_r <= S_RD;
        S_RD:   st_r <= S_EXE;
        S_EXE: begin
          priority if (item_r.op == gip_pkg::OP_READ) begin
            st_r <= S_DIV;
          end else if (item_r.op == gip_pkg::OP_SAMPLE && ent_r.gap != '0 && ent_r.have) begin
            st_r <= S_LOOP;
          end else begin
            st_r <= S_WB;
          end
        end
        S_LOOP: if (i_r == ent_r.gap) st_r <= S_WB;
        S_DIV:  st_r <= S_RES;
        S_RES:  if (res_go) st_r <= S_WB;
        S_WB:   st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (st_r)
      S_IDLE: item_r <= pop_item;
      S_RD: begin
        ent_r  <= rd_q;
        neg_r  <= rd_q.sum[gip_pkg::SUM_W-1];
        prod_r <= (item_r.op == gip_pkg::OP_READ) ? mag : gip_pkg::sum_t'(prod);
      end
      S_EXE: begin
        i_r   <= gip_pkg::gap_t'(1);
        dq_r  <= t3b[gip_pkg::LOW_W+gip_pkg::X_W-1:gip_pkg::LOW_W];
        big_r <= |prod_r[gip_pkg::SUM_W-1:gip_pkg::SAT_SH];
        unique case (item_r.op)
          gip_pkg::OP_SAMPLE: begin
            ent_r.sum <= ent_r.sum + prod_r + twov;
            ent_r.dur <= ent_r.dur + (v_pos ? gip_pkg::DUR_STEP : '0)
                       + ((v_pos && !ent_r.have) ? g3[gip_pkg::DUR_W-1:0] : '0);
            if (!(ent_r.gap != '0 && ent_r.have)) begin
              ent_r.gap  <= '0;
              ent_r.last <= item_r.val;
              ent_r.have <= 1'b1;
            end
          end
          gip_pkg::OP_MISS_LAST: begin
            if (ent_r.have) begin
              ent_r.sum <= ent_r.sum + prod_r;
              ent_r.dur <= ent_r.dur + g3[gip_pkg::DUR_W-1:0];
            end else begin
              ent_r.sum <= gip_pkg::MISSING_SUM;
            end
          end
          gip_pkg::OP_MISS_STEP: begin
            if (ent_r.gap != '1) ent_r.gap <= ent_r.gap + gip_pkg::gap_t'(1);
          end
          default: ;
        endcase
      end
      S_LOOP: begin
        i_r       <= i_r + gip_pkg::gap_t'(1);
        ent_r.dur <= ent_r.dur + (v_pos ? gip_pkg::dur_t'(fa) : '0)
                   + (l_pos ? gip_pkg::dur_t'(fb) : '0);
        if (i_r == ent_r.gap) begin
          ent_r.gap  <= '0;
          ent_r.last <= item_r.val;
          ent_r.have <= 1'b1;
        end
      end
      S_DIV: q_r <= qprod[gip_pkg::RCP_SH+gip_pkg::Q_W-1:gip_pkg::RCP_SH];
      S_RES: begin
        if (res_go) begin
          out_pix_r <= item_r.pix;
          out_mm_r  <= mm;
          out_dur_r <= ent_r.dur;
          ent_r     <= '0;
        end
      end
      default: ;
    endcase
  end

endmodule
